// ----- rtl/fbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// fbsp_pkg: shared types and tables for the five-bit symbol packer
// Alphabet lookup, beat counts per group, and the job record that travels
// from the front end to the back end.
// ----------------------------------------------------------------------------
package fbsp_pkg;

   localparam int unsigned SYM_W          = 5;
   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned GROUP_W        = 40;
   localparam int unsigned SYMS_PER_GROUP = 8;
   localparam int unsigned BYTES_PER_GROUP = 5;
   localparam int unsigned ALPHABET_SIZE  = 28;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // letter c of the alphabet sits at bits [8*(27-c) +: 8]
   localparam logic [8*ALPHABET_SIZE-1:0] ALPHABET_STR = "ABCDEFGHIJKLMNOPQRSTUVWYZX*-";

   typedef struct packed {
      logic [GROUP_W-1:0] bits;
      logic [3:0]         n_out;  // beats to emit, 1..8
      logic               mode;
      logic               last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // unknown characters map to code 0
   function automatic logic [SYM_W-1:0] code_of(input logic [BYTE_W-1:0] ch);
      logic [SYM_W-1:0] code;
      logic             found;
      code  = '0;
      found = 1'b0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         if (!found && ALPHABET_STR[8*(ALPHABET_SIZE-1-i) +: 8] == ch) begin
            code  = SYM_W'(i);
            found = 1'b1;
         end
      end
      return code;
   endfunction

   // codes past the alphabet decode to NUL
   function automatic logic [BYTE_W-1:0] char_of(input logic [SYM_W-1:0] code);
      logic [SYM_W-1:0] pos;
      pos = SYM_W'(ALPHABET_SIZE - 1) - code;
      if (code < SYM_W'(ALPHABET_SIZE)) begin
         return ALPHABET_STR[{pos, 3'b000} +: 8];
      end
      return '0;
   endfunction

   // ceil(5n/8)
   function automatic logic [3:0] enc_beats(input logic [3:0] n);
      logic [3:0] r;
      unique case (n)
         4'd1:    r = 4'd1;
         4'd2:    r = 4'd2;
         4'd3:    r = 4'd2;
         4'd4:    r = 4'd3;
         4'd5:    r = 4'd4;
         4'd6:    r = 4'd4;
         4'd7:    r = 4'd5;
         4'd8:    r = 4'd5;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   // floor(8k/5)
   function automatic logic [3:0] dec_beats(input logic [3:0] k);
      logic [3:0] r;
      unique case (k)
         4'd1:    r = 4'd1;
         4'd2:    r = 4'd3;
         4'd3:    r = 4'd4;
         4'd4:    r = 4'd6;
         4'd5:    r = 4'd8;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/fbsp_front.sv -----
// ----------------------------------------------------------------------------
// fbsp_front: input side of the packer
// Holds the mode register, classifies each beat and builds the group; a full
// group or a last beat becomes a job for the queue.
// ----------------------------------------------------------------------------
module fbsp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wen,
   input  logic                    csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_byte,
   input  logic                    req_last,
   input  fbsp_pkg::q_status_type  q_status,
   output logic                    push,
   output fbsp_pkg::job_type       push_job
);
   import fbsp_pkg::*;

   logic               mode_ff, mode_in;
   logic [GROUP_W-1:0] bits_ff, bits_in;
   logic [3:0]         count_ff, count_in;

   logic               accept;
   logic [3:0]         limit;
   logic [3:0]         cur_count;
   logic [GROUP_W-1:0] cur_bits;
   logic [GROUP_W-1:0] new_bits;
   logic [3:0]         new_count;
   logic [5:0]         shift;
   logic               flush;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      limit     = (mode_ff == MODE_DECODE) ? 4'(BYTES_PER_GROUP) : 4'(SYMS_PER_GROUP);
      // a count at or past the limit restarts the group
      cur_count = (count_ff >= limit) ? 4'd0 : count_ff;
      cur_bits  = (count_ff >= limit) ? '0 : bits_ff;
      if (mode_ff == MODE_DECODE) begin
         shift    = 6'd32 - {cur_count[2:0], 3'b000};
         new_bits = cur_bits | ({32'b0, req_byte} << shift);
      end else begin
         shift    = 6'd35 - (6'(cur_count) * 6'd5);
         new_bits = cur_bits | ({35'b0, code_of(req_byte)} << shift);
      end
      new_count = cur_count + 4'd1;
      flush     = (new_count == limit) || req_last;
   end

   assign push           = accept && flush;
   assign push_job.bits  = new_bits;
   assign push_job.n_out = (mode_ff == MODE_DECODE) ? dec_beats(new_count)
                                                    : enc_beats(new_count);
   assign push_job.mode  = mode_ff;
   assign push_job.last  = req_last;

   always_comb begin
      mode_in  = mode_ff;
      bits_in  = bits_ff;
      count_in = count_ff;
      if (csr_wen) begin
         mode_in  = csr_wdata;
         bits_in  = '0;
         count_in = '0;
      end else if (accept) begin
         bits_in  = flush ? '0 : new_bits;
         count_in = flush ? 4'd0 : new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         bits_ff  <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         bits_ff  <= bits_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/fbsp_queue.sv -----
// ----------------------------------------------------------------------------
// fbsp_queue: short job queue between front and back end
// Register-based FIFO with combinational head.
// ----------------------------------------------------------------------------
module fbsp_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  fbsp_pkg::job_type       push_job,
   input  logic                    pop,
   output fbsp_pkg::job_type       head_job,
   output fbsp_pkg::q_status_type  q_status
);
   import fbsp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_job       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/fbsp_back.sv -----
// ----------------------------------------------------------------------------
// fbsp_back: output side of the packer
// Takes one job at a time and walks its beats into the output register,
// one beat per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module fbsp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  fbsp_pkg::job_type       head_job,
   input  fbsp_pkg::q_status_type  q_status,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_byte,
   output logic                    rsp_last
);
   import fbsp_pkg::*;

   job_type     job_ff, job_in;
   logic        active_ff, active_in;
   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;

   logic        can_load;
   logic        emit;
   logic        final_beat;
   logic [7:0]  beat_byte;

   function automatic logic [7:0] enc_byte(input logic [GROUP_W-1:0] b,
                                           input logic [2:0] i);
      logic [7:0] r;
      unique case (i)
         3'd0:    r = b[39:32];
         3'd1:    r = b[31:24];
         3'd2:    r = b[23:16];
         3'd3:    r = b[15:8];
         default: r = b[7:0];
      endcase
      return r;
   endfunction

   function automatic logic [SYM_W-1:0] dec_code(input logic [GROUP_W-1:0] b,
                                                 input logic [2:0] i);
      logic [SYM_W-1:0] r;
      unique case (i)
         3'd0:    r = b[39:35];
         3'd1:    r = b[34:30];
         3'd2:    r = b[29:25];
         3'd3:    r = b[24:20];
         3'd4:    r = b[19:15];
         3'd5:    r = b[14:10];
         3'd6:    r = b[9:5];
         default: r = b[4:0];
      endcase
      return r;
   endfunction

   assign can_load   = !valid_ff || !rsp_stall;
   assign emit       = active_ff && can_load;
   assign final_beat = ({1'b0, idx_ff} == job_ff.n_out - 4'd1);
   assign pop        = !q_status.empty && (!active_ff || (emit && final_beat));
   assign beat_byte  = (job_ff.mode == MODE_DECODE) ? char_of(dec_code(job_ff.bits, idx_ff))
                                                    : enc_byte(job_ff.bits, idx_ff);

   always_comb begin
      job_in    = job_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      if (pop) begin
         job_in    = head_job;
         active_in = 1'b1;
         idx_in    = '0;
      end else if (emit && final_beat) begin
         active_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (can_load) begin
         valid_in = emit;
         byte_in  = beat_byte;
         last_in  = job_ff.last && final_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;

endmodule

// ----- rtl/five_bit_symbol_packer.sv -----
// ----------------------------------------------------------------------------
// five_bit_symbol_packer: 5-bit protein alphabet packer / unpacker
// Encode: eight characters in, five packed bytes out. Decode: five bytes in,
// eight characters out. First symbol goes to the most significant bits.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    req_byte, req_last
//   rsp      out  rsp_valid/stall    rsp_byte, rsp_last
//   csr      in   csr_wen            csr_wdata (mode)
//
// Front end takes one req beat per cycle and stalls only while the job
// queue is full. Back end emits one rsp beat per cycle unless rsp_stall
// holds it, so a group yields five (encode) or eight (decode) output
// beats; in decode the back end sets the sustained rate.
// A closing beat passes the queue entry, job register and output register.
// Synchronous active-high reset empties queue and output, mode = encode.
// A csr write drops any partial group.
// ----------------------------------------------------------------------------
module five_bit_symbol_packer #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte,
   output logic        rsp_last
);
   import fbsp_pkg::*;

   // front -> queue
   logic         push;
   job_type      push_job;
   // queue -> back
   logic         pop;
   job_type      head_job;
   q_status_type q_status;

   fbsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   // jobs decouple input grouping from output beat sequencing
   fbsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   fbsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last)
   );

   // never push into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("job pushed into full queue");

   // never pop an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("job popped from empty queue");

   // every job carries at least one beat
   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.n_out != 4'd0))
      else $error("job with no beats");

   // a job pushed into an empty queue is not lost: the queue holds it or the back end pops it
   a_push_reaches_pop: assert property (@(posedge clock) disable iff (reset)
      push && q_status.empty |=> !q_status.empty || pop || $past(pop))
      else $error("pushed job lost");

endmodule

// ----- bench/five_bit_symbol_packer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_bit_symbol_packer_test: self-checking bench for the 5-bit packer
// Drives character / packed-byte beats into the packer under random sender
// gaps and receiver stalls. A behavioral model of the packer predicts every
// rsp beat, and a monitor checks rsp beats in order against those predictions.
// ----------------------------------------------------------------------------
module five_bit_symbol_packer_test;
   import fbsp_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int SETTLE_TICKS = 8;      // exceeds the rsp latency, covers held groups
   localparam int RANDOM_BEATS = 260;
   localparam int CALM_FROM    = 220;    // last random beats run with no gaps/stalls

   // ------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       csr_wen   = 1'b0;
   logic       csr_wdata = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte  = 8'h00;
   logic       req_last  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_byte;
   logic       rsp_last;

   five_bit_symbol_packer u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // Packer model: mirrors the group register, its fill count and mode.
   // Predicted rsp beats wait in expected_beats, oldest first.
   // ------------------------------------------------------------------
   typedef struct {
      logic [7:0] data;
      logic       last;
   } rsp_beat_type;

   rsp_beat_type expected_beats[$];
   logic [39:0]  group_reg   = '0;
   logic [3:0]   group_fill  = '0;
   logic         packer_mode = MODE_ENCODE;

   string letters = "ABCDEFGHIJKLMNOPQRSTUVWYZX*-";

   int errors        = 0;
   int beats_sent    = 0;
   int beats_checked = 0;
   int mode_writes   = 0;
   int full_groups   = 0;
   int flushes       = 0;
   bit pace_on       = 1'b1;   // random sender gaps
   bit calm          = 1'b0;   // receiver never stalls

   // look up the 5-bit code of a character; anything outside the alphabet is 0
   function automatic logic [4:0] symbol_code(input logic [7:0] ch);
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         if (letters[i] == ch) begin
            return 5'(i);
         end
      end
      return 5'd0;
   endfunction

   // codes 28..31 have no letter and come back as NUL
   function automatic logic [7:0] symbol_char(input logic [4:0] code);
      if (code < 5'(ALPHABET_SIZE)) begin
         return letters[code];
      end
      return 8'h00;
   endfunction

   // Advance the model by one accepted req beat and queue its rsp beats.
   task automatic predict_packer(input logic [7:0] data, input logic last);
      int           n_out;
      rsp_beat_type b;
      n_out = 0;
      if (packer_mode == MODE_ENCODE) begin
         // symbols land from bit 39 downward
         group_reg  = group_reg | (40'(symbol_code(data)) << (35 - 5 * group_fill));
         group_fill = group_fill + 4'd1;
         if (group_fill == 4'(SYMS_PER_GROUP) || last) begin
            n_out = (5 * group_fill + 7) / 8;    // ceil, low bits zero padded
            for (int i = 0; i < n_out; i++) begin
               b.data = 8'(group_reg >> (32 - 8 * i));
               b.last = last && (i == n_out - 1);
               expected_beats.push_back(b);
            end
         end
      end else begin
         group_reg  = group_reg | (40'(data) << (32 - 8 * group_fill));
         group_fill = group_fill + 4'd1;
         if (group_fill == 4'(BYTES_PER_GROUP) || last) begin
            n_out = (8 * group_fill) / 5;        // floor, missing bytes read as zero
            for (int i = 0; i < n_out; i++) begin
               b.data = symbol_char(5'(group_reg >> (35 - 5 * i)));
               b.last = last && (i == n_out - 1);
               expected_beats.push_back(b);
            end
         end
      end
      if (n_out > 0) begin
         if (last) flushes++;
         else full_groups++;
         group_reg  = '0;
         group_fill = '0;
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall bursts between runs of free cycles
   // ------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_left <= $urandom_range(0, 24);   // sometimes a long open stretch
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 15);
      end
   end

   // ------------------------------------------------------------------
   // rsp monitor: every accepted beat must match the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (expected_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected rsp beat, expected none, got byte %h last %b",
                     $time, rsp_byte, rsp_last);
         end else begin
            e = expected_beats.pop_front();
            if (rsp_byte !== e.data) begin
               errors++;
               $display("%0t: rsp_byte mismatch, expected %h, got %h",
                        $time, e.data, rsp_byte);
            end
            if (rsp_last !== e.last) begin
               errors++;
               $display("%0t: rsp_last mismatch, expected %b, got %b",
                        $time, e.last, rsp_last);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared stimulus tasks; all are entered and left on a rising edge
   // ------------------------------------------------------------------

   // Send one req beat, optionally after a random gap, and wait for it to be taken.
   // valid is left high so back-to-back beats need no extra NBA in one step.
   task automatic send_beat(input logic [7:0] data, input logic last);
      if (pace_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte  <= data;
      req_last  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_packer(data, last);
      beats_sent++;
   endtask

   // Hold off the sender until every predicted beat is out, then let any
   // group the packer still holds settle.
   task automatic drain_packer;
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Mode write; only issued after drain_packer. Drops any partial group.
   task automatic write_mode(input logic m);
      csr_wen   <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_wen     <= 1'b0;
      packer_mode  = m;
      group_reg    = '0;
      group_fill   = '0;
      mode_writes++;
   endtask

   // mostly alphabet letters, some arbitrary bytes that fall back to code 0
   function automatic logic [7:0] random_char;
      if ($urandom_range(0, 7) != 0) begin
         return letters[$urandom_range(0, ALPHABET_SIZE - 1)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Encode from reset mode: a full group closed by last, holding the
   // alphabet's tail letters, unknown characters and both byte extremes;
   // then partial flushes of three symbols and of one symbol.
   task automatic test_encode_groups;
      logic [7:0] grp [8];
      grp = '{"Z", "X", "*", "-", "?", 8'h00, 8'hFF, "a"};
      foreach (grp[i]) send_beat(grp[i], i == 7);
      send_beat("M", 1'b0);
      send_beat("N", 1'b0);
      send_beat("O", 1'b1);
      send_beat("-", 1'b1);
      drain_packer();
   endtask

   // Decode: a full group with last holding codes 24..31 (the upper four
   // come back as NUL), a one-byte flush, and a four-byte flush.
   task automatic test_decode_groups;
      logic [7:0] grp [5];
      logic [7:0] tail [4];
      grp  = '{8'hC6, 8'h75, 8'hBE, 8'h77, 8'hDF};
      tail = '{8'hA5, 8'h5A, 8'h0F, 8'hF0};
      write_mode(MODE_DECODE);
      foreach (grp[i]) send_beat(grp[i], i == 4);
      send_beat(8'h80, 1'b1);
      foreach (tail[i]) send_beat(tail[i], i == 3);
      drain_packer();
   endtask

   // A mode write in the middle of a group throws the partial group away.
   task automatic test_mode_switch_drops_group;
      send_beat(8'h3C, 1'b0);
      send_beat(8'hE1, 1'b0);
      drain_packer();
      write_mode(MODE_ENCODE);
      send_beat("B", 1'b1);
      drain_packer();
   endtask

   // Random phases: each picks a mode, then runs several streams. Most
   // streams end in last; some stop short and leave a group that the next
   // stream continues or the next mode write drops. The tail runs at full rate.
   task automatic test_random_streams;
      int sent;
      int len;
      bit closed;
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         if (sent >= CALM_FROM) begin
            pace_on = 1'b0;
            calm    = 1'b1;
         end
         drain_packer();
         write_mode(logic'($urandom_range(0, 1)));
         repeat ($urandom_range(2, 5)) begin
            len    = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24)
                                                 : $urandom_range(1, 8);
            closed = $urandom_range(0, 7) != 0;
            for (int i = 0; i < len; i++) begin
               send_beat(packer_mode == MODE_ENCODE ? random_char()
                                                    : 8'($urandom_range(0, 255)),
                         closed && i == len - 1);
            end
            sent += len;
            // sender sometimes waits for the packer to empty completely
            if (pace_on && $urandom_range(0, 3) == 0) drain_packer();
         end
      end
      drain_packer();
   endtask

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_encode_groups();
      test_decode_groups();
      test_mode_switch_drops_group();
      test_random_streams();

      $display("covered %0d req beats over %0d mode writes: %0d full groups, %0d flushes",
               beats_sent, mode_writes, full_groups, flushes);
      $display("checked %0d rsp beats, %0d mismatches", beats_checked, errors);
      if (errors == 0) begin
         $display("five_bit_symbol_packer_test: PASS");
      end else begin
         $display("five_bit_symbol_packer_test: FAIL");
      end
      $finish;
   end

   // watchdog, far past the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout with %0d rsp beats still expected", expected_beats.size());
      $display("five_bit_symbol_packer_test: FAIL");
      $finish;
   end

endmodule
